// File: rtl/fdsr_pkg.sv
// Shared types and constants for the fixed-point to decimal text unit.
// Holds the controller state type, the command and status structs and the character codes.
// No dependencies.
`default_nettype none

package fdsr_pkg;

	localparam int VALUE_W = 38;
	localparam int CFG_W   = 3;
	localparam int CHAR_W  = 8;
	localparam int DIG_W   = 4;

	localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
	localparam logic [CHAR_W-1:0] CH_DOT   = 8'h2E;
	localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;

	localparam logic [DIG_W-1:0] DIG_NINE = 4'd9;
	localparam logic [DIG_W-1:0] DIG_FIVE = 4'd5;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CONV,
		ST_ROUND,
		ST_PLACE,
		ST_EMIT
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;
		logic step;
		logic round;
		logic place;
		logic emit;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic conv_last;
		logic emit_last;
	} sts_t;

	// Power of ten, evaluated at elaboration for parameter-derived constants.
	function automatic logic [63:0] pow10(input int n);
		logic [63:0] r;
		r = 64'd1;
		for (int i = 0; i < n; i++) begin
			r = r * 64'd10;
		end
		return r;
	endfunction

endpackage

`default_nettype wire

// File: rtl/fixed_to_decimal_string_rounded_unit.sv
// A signed fixed-point value (value_fixed / 2^FRAC_BITS) taken on start is printed as
// decimal ASCII text, one character per cycle on out_char with out_valid high: an optional
// '-', the integer part without leading zeros, '.', then decimal_places fraction digits
// (clamped to MAX_DECIMALS), rounded half up; last_char marks the final character and
// overflow marks every character of a number saturated to nines. The receiver cannot stall
// the output. An item keeps busy high through conversion by the one-bit-per-cycle binary
// to BCD shifter alongside fraction digit generation, then rounding and start placement,
// then the characters, and a new start is taken in the cycle after the last character.
// decimal_places resets to 2 and is written over the cfg channel while busy is low.
`default_nettype none

module fixed_to_decimal_string_rounded_unit #(
	parameter int INT_DIGITS   = 5,
	parameter int FRAC_BITS    = 20,
	parameter int MAX_DECIMALS = 5
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 start,
	output logic                                      busy,
	input  wire logic signed [fdsr_pkg::VALUE_W-1:0]  value_fixed,
	input  wire logic                                 cfg_valid,
	output logic                                      cfg_ready,
	input  wire logic        [fdsr_pkg::CFG_W-1:0]    cfg_data,
	output logic                                      out_valid,
	output logic             [fdsr_pkg::CHAR_W-1:0]   out_char,
	output logic                                      last_char,
	output logic                                      overflow
);

	fdsr_pkg::cmd_t cmd;
	fdsr_pkg::sts_t sts;
	logic [fdsr_pkg::CFG_W-1:0] dec_places_q;

	assign cfg_ready = ~busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dec_places_q <= fdsr_pkg::CFG_W'(2);
		end else if (cfg_valid && cfg_ready) begin
			dec_places_q <= cfg_data;
		end
	end

	fdsr_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.sts       (sts),
		.cmd       (cmd),
		.busy      (busy),
		.out_valid (out_valid)
	);

	fdsr_dp #(
		.INT_DIGITS   (INT_DIGITS),
		.FRAC_BITS    (FRAC_BITS),
		.MAX_DECIMALS (MAX_DECIMALS)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.value_fixed    (value_fixed),
		.decimal_places (dec_places_q),
		.sts            (sts),
		.out_char       (out_char),
		.last_char      (last_char),
		.overflow       (overflow)
	);

	// Characters only appear while an item is in flight.
	a_valid_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> busy)
		else $error("character beat while not busy");

	// An accepted start always launches the conversion.
	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("start accepted but unit not busy");

	// The final character ends the text: no beat follows it directly.
	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && last_char) |=> !out_valid)
		else $error("beat after last character");

	// Within one text the characters come back to back with the same overflow flag.
	a_text_steady: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !last_char) |=> (out_valid && overflow == $past(overflow)))
		else $error("text interrupted or overflow flag changed");

endmodule

`default_nettype wire

// File: rtl/fdsr_ctrl.sv
// Controller state machine for the fixed-point to decimal text unit.
// Sequences load, conversion steps, rounding, start placement and character output.
// Depends on fdsr_pkg.
`default_nettype none

module fdsr_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	input  wire fdsr_pkg::sts_t sts,
	output fdsr_pkg::cmd_t     cmd,
	output logic               busy,
	output logic               out_valid
);

	fdsr_pkg::state_t state_q, state_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= fdsr_pkg::ST_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	always_comb begin
		state_nx  = state_q;
		cmd       = '0;
		busy      = 1'b1;
		out_valid = 1'b0;
		case (state_q)
			fdsr_pkg::ST_IDLE: begin
				busy = 1'b0;
				if (start) begin
					cmd.load = 1'b1;
					state_nx = fdsr_pkg::ST_CONV;
				end
			end
			fdsr_pkg::ST_CONV: begin
				cmd.step = 1'b1;
				if (sts.conv_last) begin
					state_nx = fdsr_pkg::ST_ROUND;
				end
			end
			fdsr_pkg::ST_ROUND: begin
				cmd.round = 1'b1;
				state_nx  = fdsr_pkg::ST_PLACE;
			end
			fdsr_pkg::ST_PLACE: begin
				cmd.place = 1'b1;
				state_nx  = fdsr_pkg::ST_EMIT;
			end
			fdsr_pkg::ST_EMIT: begin
				cmd.emit  = 1'b1;
				out_valid = 1'b1;
				if (sts.emit_last) begin
					state_nx = fdsr_pkg::ST_IDLE;
				end
			end
			default: begin
				state_nx = fdsr_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

// File: rtl/fdsr_dp.sv
// Datapath of the fixed-point to decimal text unit: sign and magnitude, binary to BCD
// of the integer part, fraction digit generation, rounding and the character select.
// Depends on fdsr_pkg.
`default_nettype none

module fdsr_dp #(
	parameter int INT_DIGITS   = 5,
	parameter int FRAC_BITS    = 20,
	parameter int MAX_DECIMALS = 5
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire fdsr_pkg::cmd_t                   cmd,
	input  wire logic [fdsr_pkg::VALUE_W-1:0]     value_fixed,
	input  wire logic [fdsr_pkg::CFG_W-1:0]       decimal_places,
	output fdsr_pkg::sts_t                        sts,
	output logic      [fdsr_pkg::CHAR_W-1:0]      out_char,
	output logic                                  last_char,
	output logic                                  overflow
);

	localparam int IW       = fdsr_pkg::VALUE_W - FRAC_BITS;
	localparam int NF       = MAX_DECIMALS + 1;
	localparam int CONV_CYC = (IW > NF) ? IW : NF;
	localparam int SW       = $clog2(CONV_CYC);
	localparam int NSLOT    = INT_DIGITS + 2 + MAX_DECIMALS;
	localparam int PW       = $clog2(NSLOT);
	localparam logic [63:0] INT_LIMIT = fdsr_pkg::pow10(INT_DIGITS);

	localparam int DW = fdsr_pkg::DIG_W;

	logic                        neg_q;
	logic                        ovf_q;
	logic [fdsr_pkg::CFG_W-1:0]  dec_q;
	logic [IW-1:0]               ishift_q;
	logic [FRAC_BITS-1:0]        frac_q;
	logic [SW-1:0]               step_q;
	logic [PW-1:0]               slot_q;
	logic [INT_DIGITS-1:0][DW-1:0] int_dig_q, int_step, int_rnd;
	logic [NF-1:0][DW-1:0]       frac_dig_q, frac_rnd;

	logic [fdsr_pkg::VALUE_W-1:0] mag;
	logic [IW-1:0]                ipart;
	logic                         ovf_load;
	logic [FRAC_BITS+3:0]         frac_x10;
	logic                         ovf_rnd;
	logic [PW-1:0]                lead_slot;

	// Sign and magnitude; the most negative input gives 2^37, which fits unsigned.
	assign mag      = value_fixed[fdsr_pkg::VALUE_W-1] ? (~value_fixed + 1'b1) : value_fixed;
	assign ipart    = mag[fdsr_pkg::VALUE_W-1:FRAC_BITS];
	assign ovf_load = ({{(64-IW){1'b0}}, ipart} >= INT_LIMIT);

	assign frac_x10 = ({4'b0000, frac_q} << 3) + ({4'b0000, frac_q} << 1);

	// One double-dabble step: correct each BCD digit, then shift the next binary bit in.
	always_comb begin
		logic [INT_DIGITS-1:0][DW-1:0] adj;
		for (int i = 0; i < INT_DIGITS; i++) begin
			adj[i] = (int_dig_q[i] >= fdsr_pkg::DIG_FIVE) ? (int_dig_q[i] + 4'd3) : int_dig_q[i];
		end
		for (int i = 0; i < INT_DIGITS; i++) begin
			if (i == 0) begin
				int_step[i] = {adj[i][DW-2:0], ishift_q[IW-1]};
			end else begin
				int_step[i] = {adj[i][DW-2:0], adj[i-1][DW-1]};
			end
		end
	end

	// Round half up on the digit after the last printed one. A digit is incremented
	// when every printed digit below it is nine; a carry out of the top saturates.
	always_comb begin
		logic                  round_up;
		logic                  frac_all_nine;
		logic                  all_nine;
		logic [NF-1:0]         below_f;
		logic [INT_DIGITS-1:0] below_i;
		logic                  run;
		round_up = 1'b0;
		for (int k = 0; k < NF; k++) begin
			if (k == int'(dec_q) && frac_dig_q[k] >= fdsr_pkg::DIG_FIVE) begin
				round_up = 1'b1;
			end
		end
		frac_all_nine = 1'b1;
		for (int k = 0; k < NF; k++) begin
			if (k < int'(dec_q) && frac_dig_q[k] != fdsr_pkg::DIG_NINE) begin
				frac_all_nine = 1'b0;
			end
		end
		for (int k = 0; k < NF; k++) begin
			below_f[k] = 1'b1;
			for (int m = 0; m < NF; m++) begin
				if (m > k && m < int'(dec_q) && frac_dig_q[m] != fdsr_pkg::DIG_NINE) begin
					below_f[k] = 1'b0;
				end
			end
		end
		for (int i = 0; i < INT_DIGITS; i++) begin
			below_i[i] = frac_all_nine;
			for (int j = 0; j < INT_DIGITS; j++) begin
				if (j < i && int_dig_q[j] != fdsr_pkg::DIG_NINE) begin
					below_i[i] = 1'b0;
				end
			end
		end
		run = 1'b1;
		for (int i = 0; i < INT_DIGITS; i++) begin
			if (int_dig_q[i] != fdsr_pkg::DIG_NINE) begin
				run = 1'b0;
			end
		end
		all_nine = frac_all_nine & run;
		ovf_rnd  = ovf_q | (round_up & all_nine);
		for (int k = 0; k < NF; k++) begin
			if (ovf_rnd) begin
				frac_rnd[k] = fdsr_pkg::DIG_NINE;
			end else if (k < int'(dec_q) && round_up && below_f[k]) begin
				frac_rnd[k] = (frac_dig_q[k] == fdsr_pkg::DIG_NINE) ? '0 : (frac_dig_q[k] + 4'd1);
			end else begin
				frac_rnd[k] = frac_dig_q[k];
			end
		end
		for (int i = 0; i < INT_DIGITS; i++) begin
			if (ovf_rnd) begin
				int_rnd[i] = fdsr_pkg::DIG_NINE;
			end else if (round_up && below_i[i]) begin
				int_rnd[i] = (int_dig_q[i] == fdsr_pkg::DIG_NINE) ? '0 : (int_dig_q[i] + 4'd1);
			end else begin
				int_rnd[i] = int_dig_q[i];
			end
		end
	end

	// Slot of the first integer digit printed: leading zeros are suppressed
	// down to the ones digit.
	always_comb begin
		lead_slot = PW'(INT_DIGITS);
		for (int j = INT_DIGITS - 1; j >= 0; j--) begin
			if (int_dig_q[INT_DIGITS-1-j] != '0) begin
				lead_slot = PW'(j + 1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= '0;
			slot_q <= '0;
		end else begin
			if (cmd.load) begin
				step_q <= '0;
			end else if (cmd.step) begin
				step_q <= step_q + 1'b1;
			end
			if (cmd.place) begin
				slot_q <= neg_q ? '0 : lead_slot;
			end else if (cmd.emit) begin
				slot_q <= (slot_q == '0) ? lead_slot : (slot_q + 1'b1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			neg_q     <= value_fixed[fdsr_pkg::VALUE_W-1];
			ovf_q     <= ovf_load;
			dec_q     <= (decimal_places > fdsr_pkg::CFG_W'(MAX_DECIMALS))
				? fdsr_pkg::CFG_W'(MAX_DECIMALS) : decimal_places;
			ishift_q  <= ipart;
			frac_q    <= mag[FRAC_BITS-1:0];
			int_dig_q <= '0;
		end else if (cmd.step) begin
			if (int'(step_q) < IW) begin
				int_dig_q <= int_step;
				ishift_q  <= ishift_q << 1;
			end
			if (int'(step_q) < NF) begin
				frac_q <= frac_x10[FRAC_BITS-1:0];
				for (int k = 0; k < NF; k++) begin
					if (int'(step_q) == k) begin
						frac_dig_q[k] <= frac_x10[FRAC_BITS+3:FRAC_BITS];
					end
				end
			end
		end else if (cmd.round) begin
			int_dig_q  <= int_rnd;
			frac_dig_q <= frac_rnd;
			ovf_q      <= ovf_rnd;
		end
	end

	// Character select over the slot sequence: sign, integer digits, point, fraction.
	always_comb begin
		out_char = fdsr_pkg::CH_MINUS;
		for (int j = 0; j < INT_DIGITS; j++) begin
			if (int'(slot_q) == j + 1) begin
				out_char = fdsr_pkg::CH_ZERO | {4'b0000, int_dig_q[INT_DIGITS-1-j]};
			end
		end
		if (int'(slot_q) == INT_DIGITS + 1) begin
			out_char = fdsr_pkg::CH_DOT;
		end
		for (int k = 0; k < MAX_DECIMALS; k++) begin
			if (int'(slot_q) == INT_DIGITS + 2 + k) begin
				out_char = fdsr_pkg::CH_ZERO | {4'b0000, frac_dig_q[k]};
			end
		end
	end

	assign last_char     = (int'(slot_q) == INT_DIGITS + 1 + int'(dec_q));
	assign overflow      = ovf_q;
	assign sts.emit_last = last_char;
	assign sts.conv_last = (int'(step_q) == CONV_CYC - 1);

endmodule

`default_nettype wire
